// File: design/modular_exponentiation_macros.svh
// ---------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every edge outside reset
`define MX_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// post must hold in the cycle after pre
`define MX_ASSERT_NEXT(lbl, ck, rstn, pre, post, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define MX_ASSERT(lbl, ck, rstn, prop, msg)
`define MX_ASSERT_NEXT(lbl, ck, rstn, pre, post, msg)

`endif

`endif

// File: design/modexp_pkg.sv
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, register map, sequencer states and unit handshake types.
// ---------------------------------------------------------------------------
package modexp_pkg;

    localparam int EXP_BITS_DEF = 63;
    localparam int MOD_BITS_DEF = 31;

    // fixed field widths
    localparam int BASE_W = 63;
    localparam int EXPN_W = 63;
    localparam int RES_W  = 31;
    localparam int CFG_W  = 31;

    // unit bit counter: holds up to BASE_W
    localparam int CNT_W = $clog2(BASE_W + 1);

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS = 3'd0;

    localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd998244353;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } mm_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

// File: design/modexp_mulmod.sv
// ---------------------------------------------------------------------------
// Shared modular multiply unit
// Bit-serial interleaved multiply-reduce: r = (a * b) mod m, one bit of b
// per cycle, MSB first. b arrives left-aligned in a BASE_W-bit word.
// ---------------------------------------------------------------------------
module modexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  modexp_pkg::mm_cmd_t         cmd,
    input  logic [MOD_BITS-1:0]         a,
    input  logic [modexp_pkg::BASE_W-1:0] b,
    input  logic [MOD_BITS-1:0]         m,
    output modexp_pkg::mm_stat_t        stat,
    output logic [MOD_BITS-1:0]         r
);
    import modexp_pkg::*;

    localparam int TW = MOD_BITS + 2;
    localparam int DW = MOD_BITS + 3;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BASE_W-1:0]   b_reg, b_next;
    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [MOD_BITS-1:0] m_reg, m_next;
    logic [MOD_BITS-1:0] r_reg, r_next;

    logic [TW-1:0]       t;
    logic [DW-1:0]       d1, d2;
    logic [MOD_BITS-1:0] red;

    // 2r + a < 3m, so at most two subtractions; both computed side by side
    always_comb
    begin
        t  = {1'b0, r_reg, 1'b0} + (b_reg[BASE_W-1] ? TW'(a_reg) : '0);
        d1 = {1'b0, t} - DW'(m_reg);
        d2 = {1'b0, t} - {2'b00, m_reg, 1'b0};
        if (!d2[DW-1])
        begin
            red = d2[MOD_BITS-1:0];
        end
        else if (!d1[DW-1])
        begin
            red = d1[MOD_BITS-1:0];
        end
        else
        begin
            red = t[MOD_BITS-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        b_next    = b_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.nbits;
            b_next    = b;
            a_next    = a;
            m_next    = m;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = red;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
        a_reg <= a_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign r         = r_reg;

`include "modular_exponentiation_macros.svh"

    `MX_ASSERT(a_mm_rem_below_mod, clk, rst_n, !done_reg || (r_reg < m_reg), "residue >= modulus")
    `MX_ASSERT(a_mm_no_restart, clk, rst_n, !cmd.start || !busy_reg, "restart while busy")
    `MX_ASSERT_NEXT(a_mm_done_pulse, clk, rst_n, done_reg, !done_reg, "done held")

endmodule

// File: design/modexp_ctrl.sv
// ---------------------------------------------------------------------------
// Square-and-multiply sequencer
// Reduces the base, then walks the exponent LSB first, issuing multiply and
// square operations to the shared unit; holds the output register.
// ---------------------------------------------------------------------------
module modexp_ctrl #(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [modexp_pkg::BASE_W-1:0] base_value,
    input  logic [EXP_BITS-1:0]           exponent,
    input  logic [MOD_BITS-1:0]           modulus,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [MOD_BITS-1:0]           result,
    output modexp_pkg::mm_cmd_t           mm_cmd,
    output logic [MOD_BITS-1:0]           mm_a,
    output logic [modexp_pkg::BASE_W-1:0] mm_b,
    input  modexp_pkg::mm_stat_t          mm_stat,
    input  logic [MOD_BITS-1:0]           mm_r
);
    import modexp_pkg::*;

    localparam int PAD_W = BASE_W - MOD_BITS;

    state_t              state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [MOD_BITS-1:0] res_reg, res_next;
    logic [MOD_BITS-1:0] out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                exp_zero, mod_zero, exp_last;
    logic                out_free;

    assign exp_zero = (exponent == '0);
    assign mod_zero = (modulus == '0);
    assign exp_last = ((exp_reg >> 1) == '0);
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (exp_zero || mod_zero) ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = exp_reg[0] ? ST_MUL : ST_SQR;
            end
            ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    state_next = exp_last ? ST_DONE : ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_stat.done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready       = 1'b0;
        mm_cmd.start   = 1'b0;
        mm_cmd.nbits   = CNT_W'(MOD_BITS);
        mm_a           = sq_reg;
        mm_b           = {acc_reg, {PAD_W{1'b0}}};
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                mm_a         = MOD_BITS'(1);
                mm_b         = base_value;
                mm_cmd.nbits = CNT_W'(BASE_W);
                if (in_valid)
                begin
                    mm_cmd.start = !exp_zero && !mod_zero;
                    exp_next     = exponent;
                    acc_next     = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    res_next     = exp_zero ? MOD_BITS'(1) : '0;
                end
            end
            ST_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    sq_next = mm_r;
                end
            end
            ST_STEP:
            begin
                mm_cmd.start = 1'b1;
                if (!exp_reg[0])
                begin
                    exp_next = exp_reg >> 1;
                    mm_b     = {sq_reg, {PAD_W{1'b0}}};
                end
            end
            ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_r;
                    exp_next = exp_reg >> 1;
                    res_next = mm_r;
                    if (!exp_last)
                    begin
                        mm_cmd.start = 1'b1;
                        mm_b         = {sq_reg, {PAD_W{1'b0}}};
                    end
                end
            end
            ST_SQR:
            begin
                if (mm_stat.done)
                begin
                    sq_next = mm_r;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

`include "modular_exponentiation_macros.svh"

    `MX_ASSERT(a_ctl_busy_state, clk, rst_n, !mm_stat.busy || state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR, "unit busy outside an arithmetic state")
    `MX_ASSERT(a_ctl_step_exp, clk, rst_n, state_reg != ST_STEP || exp_reg != '0, "step entered with exhausted exponent")
    `MX_ASSERT_NEXT(a_ctl_zero_exp, clk, rst_n, in_valid && in_ready && exp_zero, state_reg == ST_DONE, "zero exponent did not finish at once")

endmodule

// File: design/modular_exponentiation.sv
// ---------------------------------------------------------------------------
// Modular exponentiation
// base_value ** exponent mod modulus by square-and-multiply over a shared
// bit-serial modular multiply unit; modulus set through an APB port.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  input    | in_valid / in_ready       | base_value[62:0], exponent[62:0]
//  output   | out_valid / out_ready     | power_result[30:0]
//  config   | psel, penable, pwrite     | paddr, pwdata, prdata (modulus @ 0)
//
//  Per item: a reduction of the base, then for each exponent bit up to the
//  top set one a step state, a square (every bit but the top) and a
//  multiply (set bits only), all on the bit-serial multiply unit. A zero
//  exponent or zero modulus skips these. in_ready is high only in idle.
//  A finished result waits in the output register; the next item may run
//  meanwhile and stalls in its last state until the register frees up.
//  Reset (rst_n, async low) restores modulus 998244353 and drops all work.
// ---------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [modexp_pkg::BASE_W-1:0] base_value,
    input  logic [modexp_pkg::EXPN_W-1:0] exponent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [modexp_pkg::RES_W-1:0]  power_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [modexp_pkg::ADDR_W-1:0] paddr,
    input  logic [modexp_pkg::DATA_W-1:0] pwdata,
    output logic [modexp_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);
    import modexp_pkg::*;

    logic [CFG_W-1:0]    modulus_reg, modulus_next;
    logic                wr_en;

    mm_cmd_t             mm_cmd;
    mm_stat_t            mm_stat;
    logic [MOD_BITS-1:0] mm_a;
    logic [BASE_W-1:0]   mm_b;
    logic [MOD_BITS-1:0] mm_r;
    logic [MOD_BITS-1:0] result;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MODULUS);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (wr_en)
        begin
            modulus_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign prdata = (paddr == ADDR_MODULUS) ? DATA_W'(modulus_reg) : '0;

    modexp_ctrl #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base_value (base_value),
        .exponent   (exponent[EXP_BITS-1:0]),
        .modulus    (modulus_reg[MOD_BITS-1:0]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .mm_cmd     (mm_cmd),
        .mm_a       (mm_a),
        .mm_b       (mm_b),
        .mm_stat    (mm_stat),
        .mm_r       (mm_r)
    );

    modexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mm_cmd),
        .a     (mm_a),
        .b     (mm_b),
        .m     (modulus_reg[MOD_BITS-1:0]),
        .stat  (mm_stat),
        .r     (mm_r)
    );

    assign power_result = RES_W'(result);

endmodule

// File: tb/modexp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the input, output and APB channels of the block. Keeps its own copy
// of the modulus register, predicts each power on input transfer and compares
// every output transfer against the oldest prediction, in order.
// ---------------------------------------------------------------------------
module modexp_checker #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [modexp_pkg::BASE_W-1:0] base_value,
    input  logic [modexp_pkg::EXPN_W-1:0] exponent,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [modexp_pkg::RES_W-1:0]  power_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [modexp_pkg::ADDR_W-1:0] paddr,
    input  logic [modexp_pkg::DATA_W-1:0] pwdata,
    output int                            mismatch_count,
    output int                            outstanding
);
    import modexp_pkg::*;

    localparam int PEND_DEPTH = 16;
    localparam logic [EXPN_W-1:0] EXP_MASK =
        (EXP_BITS >= EXPN_W) ? {EXPN_W{1'b1}} : (({{(EXPN_W-1){1'b0}}, 1'b1} << EXP_BITS) - 1);
    localparam logic [CFG_W-1:0] MOD_MASK =
        (MOD_BITS >= CFG_W) ? {CFG_W{1'b1}} : (({{(CFG_W-1){1'b0}}, 1'b1} << MOD_BITS) - 1);

    logic [CFG_W-1:0] modulus_shadow;
    logic [RES_W-1:0] pending_powers[PEND_DEPTH];
    logic [RES_W-1:0] want_power;
    int               pend_rd;
    int               pend_wr;

    // square-and-multiply from the lsb up; operands stay below 2^31 so
    // every product fits in 64 bits
    function automatic logic [RES_W-1:0] expected_power(
        input logic [BASE_W-1:0] b,
        input logic [EXPN_W-1:0] e,
        input logic [CFG_W-1:0]  m
    );
        logic [EXPN_W-1:0] e_used;
        logic [63:0]       m_used;
        logic [63:0]       acc;
        logic [63:0]       sq;
        e_used = e & EXP_MASK;
        m_used = {33'd0, m & MOD_MASK};
        if (e_used == '0)
            return RES_W'(1);   // no reduction, even for modulus one
        if (m_used == 64'd0)
            return RES_W'(0);
        acc = 64'd1 % m_used;
        sq  = {1'b0, b} % m_used;
        for (int i = 0; i < EXP_BITS; i++)
        begin
            if (e_used[i])
                acc = (acc * sq) % m_used;
            sq = (sq * sq) % m_used;
        end
        return acc[RES_W-1:0];
    endfunction

    initial mismatch_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_shadow = MODULUS_RESET;
            pend_rd        = 0;
            pend_wr        = 0;
            outstanding    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pend_wr == pend_rd)
                begin
                    mismatch_count++;
                    $display("%0t: power_result transfer with nothing pending: expected none, got %0d",
                             $time, power_result);
                end
                else
                begin
                    want_power = pending_powers[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    if (power_result !== want_power)
                    begin
                        mismatch_count++;
                        $display("%0t: power_result mismatch: expected %0d, got %0d",
                                 $time, want_power, power_result);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (pend_wr - pend_rd >= PEND_DEPTH)
                begin
                    mismatch_count++;
                    $display("%0t: too many items in flight: expected at most %0d, got %0d",
                             $time, PEND_DEPTH, pend_wr - pend_rd + 1);
                end
                else
                begin
                    pending_powers[pend_wr % PEND_DEPTH] =
                        expected_power(base_value, exponent, modulus_shadow);
                    pend_wr++;
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_MODULUS)
                modulus_shadow = pwdata[CFG_W-1:0];
            outstanding = pend_wr - pend_rd;
        end
    end

endmodule

// File: tb/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Directed corner items at the reset modulus, then random bursts of items
// across a series of moduli written over APB (one, the largest, two, zero,
// random ones, 1000000007, the reset one). The output side stalls on shifting
// patterns and holds off for long stretches to back the block up. Checking
// lives in modexp_checker.
module modular_exponentiation_tb;
    import modexp_pkg::*;

    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int HOLD_OFF_EVERY  = 700;
    localparam int DRAIN_CYCLES    = 64;
    localparam int NUM_PHASES      = 9;
    localparam int PHASE_ITEMS     = 245;
    localparam int TRIVIAL_ITEMS   = 40;
    localparam logic [BASE_W-1:0] ALL_ONES = {BASE_W{1'b1}};
    localparam logic [BASE_W-1:0] TOP_BIT  = {1'b1, {(BASE_W-1){1'b0}}};
    localparam logic [BASE_W-1:0] ALT_A    = 63'h5555_5555_5555_5555;
    localparam logic [BASE_W-1:0] ALT_B    = 63'h2AAA_AAAA_AAAA_AAAA;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BASE_W-1:0] base_value;
    logic [EXPN_W-1:0] exponent;
    logic              out_valid;
    logic              out_ready;
    logic [RES_W-1:0]  power_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatch_count;
    int                outstanding;
    int                burst_left;
    bit                gaps_on;
    logic [CFG_W-1:0]  cur_modulus;

    modular_exponentiation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    modexp_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_value     (base_value),
        .exponent       (exponent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .power_result   (power_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #2 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [BASE_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[BASE_W-1:0];
    endfunction

    // mostly wide randoms, plus small values and values near multiples of m
    function automatic logic [BASE_W-1:0] random_base(input logic [CFG_W-1:0] m);
        logic [63:0] k;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel <= 4 || (sel >= 7 && m == '0))
            return rand63();
        if (sel == 5)
            return BASE_W'($urandom_range(0, 20));
        if (sel == 6)
            return ALL_ONES;
        k = 64'($urandom_range(0, 32'h7FFF_FFFF));
        return BASE_W'(k * m + 64'($urandom_range(0, 1)) + ((sel == 9) ? 64'(m) - 1 : 64'd0));
    endfunction

    // run time grows with exponent width, so keep most exponents narrow
    function automatic logic [EXPN_W-1:0] random_exponent();
        logic [EXPN_W-1:0] e;
        int                sel;
        int                w;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return '0;
        if (sel < 6)
            return rand63();
        if (sel < 8)
            return rand63() | TOP_BIT;
        w = $urandom_range(1, 12);
        e = rand63() & ((EXPN_W'(1) << w) - 1);
        return e | (EXPN_W'(1) << (w - 1));
    endfunction

    task automatic send_item(input logic [BASE_W-1:0] b, input logic [EXPN_W-1:0] e);
        @(negedge clk);
        in_valid   = 1'b1;
        base_value = b;
        exponent   = e;
        do @(posedge clk); while (!in_ready);
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                @(negedge clk);
                in_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // receiver: changing stall modes plus periodic long hold-offs
    initial
    begin
        int         delivered;
        int         next_hold;
        int         hold_left;
        int         mode;
        int         mode_left;
        int         cyc;
        logic [7:0] stall_pattern;
        delivered     = 0;
        next_hold     = 300;
        hold_left     = 0;
        mode          = 0;
        mode_left     = 0;
        cyc           = 0;
        stall_pattern = 8'hFF;
        out_ready     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                delivered++;
            @(negedge clk);
            cyc++;
            if (mode_left == 0)
            begin
                mode          = $urandom_range(0, 3);
                mode_left     = $urandom_range(50, 400);
                stall_pattern = 8'($urandom()) | 8'h01;
            end
            mode_left--;
            if (delivered >= next_hold)
            begin
                next_hold += HOLD_OFF_EVERY;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = ($urandom_range(0, 3) != 0);
                    2: out_ready = stall_pattern[cyc % 8];
                    default:
                    begin
                        if ($urandom_range(0, 15) == 0)
                            hold_left = $urandom_range(5, 40);
                        out_ready = 1'b1;
                    end
                endcase
            end
        end
    end

    initial
    begin
        logic [DATA_W-1:0] wr_value;
        int                n_items;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        base_value = '0;
        exponent   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        gaps_on    = 1'b0;
        burst_left = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // corners at the reset modulus
        cur_modulus = MODULUS_RESET;
        send_item('0, '0);
        send_item(ALL_ONES, '0);
        send_item('0, 1);
        send_item('0, ALL_ONES);
        send_item(ALL_ONES, ALL_ONES);
        send_item(ALL_ONES, 1);
        send_item(1, ALL_ONES);
        send_item(1, '0);
        send_item(BASE_W'(MODULUS_RESET) - 1, 2);
        send_item(BASE_W'(MODULUS_RESET), 5);
        send_item(BASE_W'(MODULUS_RESET) + 1, ALL_ONES);
        send_item(2, EXPN_W'(MODULUS_RESET) - 1);
        send_item(3, TOP_BIT);
        send_item(TOP_BIT, 3);
        send_item(ALT_A, ALT_B);
        send_item(ALT_B, ALT_A);
        send_item(2, 62);
        send_item(123456789, 1);
        send_item(7, 2);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: wr_value = 32'd1;
                1: wr_value = 32'h7FFF_FFFF;
                2: wr_value = 32'd2;
                3: wr_value = 32'd0;
                4: wr_value = 32'h8000_0000 | $urandom_range(3, 65535);  // bit 31 is not stored
                5: wr_value = 32'd1_000_000_007;
                6: wr_value = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
                7: wr_value = $urandom_range(3, 1000);
                default: wr_value = 32'(MODULUS_RESET);
            endcase
            apb_write(ADDR_MODULUS, wr_value);
            cur_modulus = wr_value[CFG_W-1:0];
            gaps_on     = (p % 3 != 2);
            burst_left  = $urandom_range(1, 16);
            n_items     = (wr_value[CFG_W-1:0] <= 1) ? TRIVIAL_ITEMS : PHASE_ITEMS;
            send_item(rand63(), '0);
            send_item(rand63(), 1);
            send_item(ALL_ONES, rand63());
            for (int i = 0; i < n_items; i++)
                send_item(random_base(cur_modulus), random_exponent());
            wait_idle();
        end

        if (mismatch_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
